>>> design/skc_pkg.sv
// Package for the sliding k-mer code block: field widths, register indexes,
// special symbol codes and the packed request and result types.
// No dependencies.
package skc_pkg;

    localparam int DEFAULT_MAX_KMER = 32;

    localparam int SYMBOL_W   = 8;
    localparam int CODE_W     = 64;
    localparam int POS_W      = 32;
    localparam int SPOS_W     = 5;
    localparam int SIGMA_W    = 7;
    localparam int KLEN_W     = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_ALPHABET_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KMER_LENGTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CLEAN_ONLY    = 2'd2;

    localparam logic [SIGMA_W-1:0] ALPHABET_SIZE_RESET = 7'd4;
    localparam logic [KLEN_W-1:0]  KMER_LENGTH_RESET   = 6'd12;
    localparam logic               CLEAN_ONLY_RESET    = 1'b0;

    localparam logic [SYMBOL_W-1:0] SYM_WILDCARD = 8'd254;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                start_req;
    } skc_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] kmer_code;
        logic              has_special;
        logic [SPOS_W-1:0] special_position;
        logic [POS_W-1:0]  window_start;
    } skc_out_t;

endpackage

>>> design/sliding_kmer_code_with_wildcards_top.sv
// Sliding k-mer code block: rolling base-sigma window code with wildcard and
// separator handling, one symbol request per cycle unless stalled.
// Depends on skc_pkg.
//
// Usage:
//   Symbol requests enter on s_valid/s_ready with s_data (symbol, start_req).
//   Results leave on m_valid/m_ready with m_data (kmer_code, has_special,
//   special_position, window_start). A request with start_req set begins a
//   new sequence. Requests that do not complete a window, and windows with a
//   special symbol while clean_only is set, give no result.
//   Path: a request passes the input register, the window update into the
//   middle register, and the fill add into the output register.
//   Throughput: one request per cycle unless stalled; the window and
//   context-queue update is a combinational feedback step of multiply-adds.
//   Reset and writes to alphabet_size or kmer_length clear the stream and
//   rebuild the power tables in a sweep over all MAX_KMER entries, one per
//   cycle, during which no request is processed (configuration writes are
//   still taken). A write to clean_only takes effect at once.
//   When the receiver stalls, the output register holds its result and the
//   input and middle registers keep accepting until they are full, then
//   s_ready drops.
module sliding_kmer_code_with_wildcards_top
    import skc_pkg::*;
#(
    parameter int MAX_KMER = DEFAULT_MAX_KMER
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  skc_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output skc_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int KW = $clog2(MAX_KMER + 1);
    localparam int IW = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
    localparam logic [KW-1:0] K_MAX    = KW'(MAX_KMER);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_KMER - 1);

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    function automatic logic [IW-1:0] wrap_idx(input logic [KW-1:0] len);
        return (len == K_MAX) ? '0 : IW'(len);
    endfunction

    // configuration
    logic [SIGMA_W-1:0] sigma_reg;
    logic [KLEN_W-1:0]  klen_reg;
    logic               clean_only_reg;
    logic [KW-1:0]      k_eff;
    logic               cfg_restart;

    // power table sweep
    logic              sweep_busy_reg;
    logic [IW-1:0]     sweep_idx_reg;
    logic [CODE_W-1:0] power_reg;
    logic [CODE_W-1:0] sweep_prod;
    logic              sweep_live;
    logic [CODE_W-1:0] pw_mem   [MAX_KMER];
    logic [CODE_W-1:0] fill_mem [MAX_KMER];

    // stream state
    logic [SYMBOL_W-1:0] win_mem [MAX_KMER];
    logic [KW-1:0]       ctx_len_mem  [MAX_KMER];
    logic [CODE_W-1:0]   ctx_code_mem [MAX_KMER];
    logic [KW-1:0]       fill_reg, fill_next;
    logic [IW-1:0]       whead_reg, whead_next;
    logic [CODE_W-1:0]   clean_code_reg, clean_code_next;
    logic [KW-1:0]       clean_len_reg, clean_len_next;
    logic [IW-1:0]       qhead_reg, qhead_next;
    logic [IW-1:0]       qtail_reg, qtail_next;
    logic [KW-1:0]       qcount_reg, qcount_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [KW-1:0]       hd_len_reg, hd_len_next;
    logic [CODE_W-1:0]   hd_code_reg, hd_code_next;

    // pipeline
    logic                in_valid_reg;
    skc_in_t             in_data_reg;
    logic                mid_valid_reg;
    logic [CODE_W-1:0]   mid_base_reg;
    logic                mid_has_reg;
    logic [SPOS_W-1:0]   mid_spos_reg;
    logic [IW-1:0]       mid_fidx_reg;
    logic [POS_W-1:0]    mid_wstart_reg;
    logic                out_valid_reg;
    skc_out_t            out_data_reg;
    logic                out_free, mid_free, proceed;

    // update step
    logic                st;
    logic [SYMBOL_W-1:0] sym;
    logic [KW-1:0]       c_fill, c_clen, c_qc, qc_p, width_m1;
    logic [IW-1:0]       c_head, c_qh, c_qt, qh_p, win_widx;
    logic [KW-1:0]       whead_inc;
    logic [CODE_W-1:0]   c_clean, lsk, dl_head, dl_clean;
    logic [POS_W-1:0]    c_pos;
    logic [SYMBOL_W-1:0] left_sym;
    logic                shifting, pop_dec, pop_out, is_special, push, emit, has;
    logic [KW-1:0]       h_len_p, push_len;
    logic [CODE_W-1:0]   h_code_p, push_code;

    always_comb begin
        if (klen_reg == '0) begin
            k_eff = KW'(1);
        end else if (klen_reg > KLEN_W'(MAX_KMER)) begin
            k_eff = K_MAX;
        end else begin
            k_eff = KW'(klen_reg);
        end
    end

    assign cfg_restart = cfg_we &&
        (cfg_addr == REG_ALPHABET_SIZE || cfg_addr == REG_KMER_LENGTH);

    assign sweep_prod = power_reg * CODE_W'(sigma_reg);
    assign sweep_live = KW'(sweep_idx_reg) < k_eff;

    assign out_free = !out_valid_reg || m_ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign proceed  = in_valid_reg && mid_free && !sweep_busy_reg;
    assign s_ready  = !in_valid_reg || proceed;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        st      = in_data_reg.start_req;
        sym     = in_data_reg.symbol;
        c_fill  = st ? '0 : fill_reg;
        c_head  = st ? '0 : whead_reg;
        c_clean = st ? '0 : clean_code_reg;
        c_clen  = st ? '0 : clean_len_reg;
        c_qh    = st ? LAST_IDX : qhead_reg;
        c_qt    = st ? LAST_IDX : qtail_reg;
        c_qc    = st ? '0 : qcount_reg;
        c_pos   = st ? '0 : pos_reg;

        shifting = c_fill >= k_eff;
        left_sym = win_mem[c_head];
        width_m1 = shifting ? k_eff - 1'b1 : c_fill;

        // drop the leftmost symbol: code * sigma - left * sigma^k
        lsk      = CODE_W'(left_sym) * power_reg;
        dl_head  = hd_code_reg * CODE_W'(sigma_reg) - lsk;
        dl_clean = c_clean * CODE_W'(sigma_reg) - lsk;

        pop_dec = shifting && c_qc != '0 && hd_len_reg != '0;
        pop_out = shifting && c_qc != '0 && hd_len_reg == '0;
        qc_p    = pop_out ? c_qc - 1'b1 : c_qc;
        qh_p    = pop_out ? ring_prev(c_qh) : c_qh;
        if (pop_out) begin
            h_len_p  = ctx_len_mem[ring_prev(c_qh)];
            h_code_p = ctx_code_mem[ring_prev(c_qh)];
        end else if (pop_dec) begin
            h_len_p  = hd_len_reg - 1'b1;
            h_code_p = dl_head;
        end else begin
            h_len_p  = hd_len_reg;
            h_code_p = hd_code_reg;
        end

        is_special = sym >= SYM_WILDCARD;
        push_len   = (qc_p == '0) ? width_m1 : c_clen;
        push_code  = (c_clen == k_eff) ? dl_clean : c_clean;
        push       = is_special && qc_p < K_MAX;

        if (!is_special) begin
            if (c_clen == k_eff) begin
                clean_code_next = dl_clean + CODE_W'(sym);
                clean_len_next  = c_clen;
            end else begin
                clean_code_next = c_clean + CODE_W'(sym) * pw_mem[wrap_idx(c_clen)];
                clean_len_next  = c_clen + 1'b1;
            end
        end else begin
            clean_code_next = '0;
            clean_len_next  = '0;
        end

        qhead_next  = qh_p;
        qtail_next  = push ? ring_prev(c_qt) : c_qt;
        qcount_next = push ? qc_p + 1'b1 : qc_p;
        if (push && qc_p == '0) begin
            hd_len_next  = push_len;
            hd_code_next = push_code;
        end else begin
            hd_len_next  = h_len_p;
            hd_code_next = h_code_p;
        end

        whead_inc = KW'(c_head) + 1'b1;
        if (shifting) begin
            win_widx   = c_head;
            fill_next  = c_fill;
            whead_next = (whead_inc < k_eff) ? IW'(whead_inc) : '0;
        end else begin
            win_widx   = IW'(c_fill);
            fill_next  = c_fill + 1'b1;
            whead_next = c_head;
        end
        pos_next = c_pos + 1'b1;

        emit = shifting || (c_fill + 1'b1 == k_eff);
        has  = qcount_next != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg      <= ALPHABET_SIZE_RESET;
            klen_reg       <= KMER_LENGTH_RESET;
            clean_only_reg <= CLEAN_ONLY_RESET;
            sweep_busy_reg <= 1'b1;
            sweep_idx_reg  <= LAST_IDX;
            power_reg      <= CODE_W'(1);
            fill_reg       <= '0;
            whead_reg      <= '0;
            clean_code_reg <= '0;
            clean_len_reg  <= '0;
            qhead_reg      <= LAST_IDX;
            qtail_reg      <= LAST_IDX;
            qcount_reg     <= '0;
            pos_reg        <= '0;
            in_valid_reg   <= 1'b0;
            mid_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ALPHABET_SIZE: sigma_reg <= SIGMA_W'(cfg_wdata);
                    REG_KMER_LENGTH:   klen_reg <= KLEN_W'(cfg_wdata);
                    REG_CLEAN_ONLY:    clean_only_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (cfg_restart) begin
                sweep_busy_reg <= 1'b1;
                sweep_idx_reg  <= LAST_IDX;
                power_reg      <= CODE_W'(1);
            end else if (sweep_busy_reg) begin
                if (sweep_live) begin
                    power_reg <= sweep_prod;
                end
                if (sweep_idx_reg == '0) begin
                    sweep_busy_reg <= 1'b0;
                end else begin
                    sweep_idx_reg <= sweep_idx_reg - 1'b1;
                end
            end

            if (cfg_restart) begin
                fill_reg       <= '0;
                whead_reg      <= '0;
                clean_code_reg <= '0;
                clean_len_reg  <= '0;
                qhead_reg      <= LAST_IDX;
                qtail_reg      <= LAST_IDX;
                qcount_reg     <= '0;
                pos_reg        <= '0;
            end else if (proceed) begin
                fill_reg       <= fill_next;
                whead_reg      <= whead_next;
                clean_code_reg <= clean_code_next;
                clean_len_reg  <= clean_len_next;
                qhead_reg      <= qhead_next;
                qtail_reg      <= qtail_next;
                qcount_reg     <= qcount_next;
                pos_reg        <= pos_next;
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proceed) begin
                in_valid_reg <= 1'b0;
            end

            if (proceed) begin
                mid_valid_reg <= emit && !(has && clean_only_reg);
            end else if (out_free) begin
                mid_valid_reg <= 1'b0;
            end

            if (out_free) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sweep_busy_reg && !cfg_restart) begin
            pw_mem[sweep_idx_reg]   <= sweep_live ? power_reg : '0;
            fill_mem[sweep_idx_reg] <= sweep_live ? sweep_prod - 1'b1 : '1;
        end

        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end

        if (proceed) begin
            win_mem[win_widx] <= sym;
            hd_len_reg        <= hd_len_next;
            hd_code_reg       <= hd_code_next;
            if (push) begin
                ctx_len_mem[c_qt]  <= push_len;
                ctx_code_mem[c_qt] <= push_code;
            end
            mid_base_reg   <= has ? hd_code_next : clean_code_next;
            mid_has_reg    <= has;
            mid_spos_reg   <= has ? SPOS_W'(hd_len_next) : '0;
            mid_fidx_reg   <= wrap_idx(hd_len_next);
            mid_wstart_reg <= c_pos - POS_W'(k_eff) + 1'b1;
        end

        if (out_free && mid_valid_reg) begin
            out_data_reg.kmer_code        <= mid_base_reg +
                (mid_has_reg ? fill_mem[mid_fidx_reg] : '0);
            out_data_reg.has_special      <= mid_has_reg;
            out_data_reg.special_position <= mid_spos_reg;
            out_data_reg.window_start     <= mid_wstart_reg;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg <= K_MAX)
        else $error("context queue count above depth");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= k_eff)
        else $error("fill count above window length");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        KW'(whead_reg) < k_eff)
        else $error("window head outside window");

endmodule
